FILE: hdl/pfs_pkg.sv
// Shared types and constants for the PLL factor search.
// Holds the reference clock figure, derived widths, reciprocal and status codes.
// No dependencies.
`timescale 1ns / 1ps

package pfs_pkg;

    // Reference clock and multiplier limit
    localparam int REF_CLOCK_HZ   = 24000000;
    localparam int MAX_MULTIPLIER = 255;

    // Widths derived from the reference clock and the 32-bit request
    localparam longint unsigned RATE_MAX = 64'hFFFF_FFFF;
    localparam int QMAX   = int'(RATE_MAX / 64'(REF_CLOCK_HZ));
    localparam int QW     = $clog2(QMAX + 1);
    localparam int RW     = $clog2(REF_CLOCK_HZ + 1);
    localparam int NHI_W  = $clog2(4 * QMAX + 4);
    localparam int MUL_W  = $clog2(MAX_MULTIPLIER + 1);
    localparam int NW     = (NHI_W > MUL_W) ? NHI_W : MUL_W;

    // Reciprocal of the reference clock: the estimate is the quotient or one below
    localparam int RECIP_SHIFT = 51;
    localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'(REF_CLOCK_HZ);
    localparam logic [31:0] RECIP      = RECIP_FULL[31:0];

    // Reference clock at the widths the datapath compares against
    localparam logic [RW-1:0]   REF_C  = RW'(REF_CLOCK_HZ);
    localparam logic [RW+1:0]   REF_X1 = (RW + 2)'(REF_CLOCK_HZ);
    localparam logic [RW+1:0]   REF_X2 = (RW + 2)'(2 * longint'(REF_CLOCK_HZ));
    localparam logic [RW+1:0]   REF_X3 = (RW + 2)'(3 * longint'(REF_CLOCK_HZ));
    localparam logic [NW-1:0]   MAX_N  = NW'(MAX_MULTIPLIER);

    // Post-divider lanes, taken in this order
    localparam int LANES = 3;
    localparam logic [2:0] DIV_VAL   [LANES] = '{3'd1, 3'd2, 3'd4};
    localparam int         DIV_SHIFT [LANES] = '{0, 1, 2};

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_ZERO  = 2'd1,
        ST_NONE  = 2'd2
    } t_status;

    // Quotient and remainder of the request by the reference clock
    typedef struct packed {
        logic          valid;
        logic [31:0]   rate;
        logic [QW-1:0] quot;
        logic [RW-1:0] rem;
    } t_div_res;

endpackage

FILE: hdl/pfs_ref_div.sv
// Three-stage divider of the requested rate by the reference clock.
// Reciprocal multiply, back-multiply, then a single correction step.
// Depends on pfs_pkg.
`timescale 1ns / 1ps

module pfs_ref_div
    import pfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_rate,
    output t_div_res    o_res
);

    logic             r1_valid, r2_valid, r3_valid;
    logic [31:0]      r1_rate, r2_rate, r3_rate;
    logic [63:0]      r1_prod;
    logic [QW-1:0]    r2_qest;
    logic [QW+RW-1:0] r2_back;
    logic [QW-1:0]    r3_quot;
    logic [RW-1:0]    r3_rem;

    logic [QW-1:0]    n_qest;
    logic [32:0]      n_diff;
    logic [32:0]      n_diff_adj;

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // Estimate quotient from the top of the reciprocal product
    assign n_qest = r1_prod[RECIP_SHIFT +: QW];

    // Remainder of the estimate lies below twice the reference clock
    assign n_diff     = {1'b0, r2_rate} - 33'(r2_back);
    assign n_diff_adj = n_diff - 33'(REF_C);

    // Advance the datapath
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_rate <= i_rate;
            r1_prod <= 64'(i_rate) * 64'(RECIP);
            r2_rate <= r1_rate;
            r2_qest <= n_qest;
            r2_back <= (QW + RW)'(n_qest) * (QW + RW)'(REF_C);
            r3_rate <= r2_rate;
            if (n_diff >= 33'(REF_C)) begin
                r3_quot <= r2_qest + QW'(1);
                r3_rem  <= n_diff_adj[RW-1:0];
            end else begin
                r3_quot <= r2_qest;
                r3_rem  <= n_diff[RW-1:0];
            end
        end
    end

    assign o_res.valid = r3_valid;
    assign o_res.rate  = r3_rate;
    assign o_res.quot  = r3_quot;
    assign o_res.rem   = r3_rem;

endmodule

FILE: hdl/pll_factor_search.sv
// Top level of the PLL factor search.
// Instantiates pfs_ref_div and works out the best multiplier per post-divider.
// Depends on pfs_pkg and pfs_ref_div.
`timescale 1ns / 1ps

// For a requested output rate this block picks the multiplier n and post-divider
// m (1, 2 or 4) whose rate floor(n * REF_CLOCK_HZ / m) comes closest from below,
// scanning n over [floor(rate/REF), floor(4*rate/REF)) up to MAX_MULTIPLIER; the
// earliest divider wins a tie. Rather than stepping through candidates, the best
// n for each divider is found in closed form, so a beat is accepted every cycle
// while the output is not stalled. Three stages divide the request by the
// reference clock, then come the per-divider limit, the per-divider multiply,
// the shortfall subtract and the output register. Status 0 means found, 1 a
// zero request, 2 no pair at or below the request; the other fields are zero
// unless status is 0. A stall on the output holds the whole pipeline.

module pll_factor_search
    import pfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_requested_rate,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_chosen_rate,
    output logic [7:0]  o_chosen_multiplier,
    output logic [2:0]  o_chosen_divider
);

    logic     n_en;
    t_div_res div_res;

    // Stage registers
    logic             r4_valid, r5_valid, r6_valid;
    logic [31:0]      r4_rate, r5_rate;
    logic             r6_zero;
    logic [NW-1:0]    r4_nstar [LANES];
    logic [NW-1:0]    r5_nstar [LANES];
    logic [NW-1:0]    r6_nstar [LANES];
    logic             r4_lv [LANES];
    logic             r5_lv [LANES];
    logic             r6_lv [LANES];
    logic [31:0]      r5_cand  [LANES];
    logic [31:0]      r6_cand  [LANES];
    logic [31:0]      r6_delta [LANES];

    // Output register
    logic             r_out_valid;
    t_status          r_out_status;
    logic [31:0]      r_out_rate;
    logic [7:0]       r_out_mul;
    logic [2:0]       r_out_div;

    // Limit stage signals
    logic [NW-1:0]    n_lo, n_hi, n_hi_m1, n_lim;
    logic [NW-1:0]    n_nmax  [LANES];
    logic [NW-1:0]    n_nstar [LANES];
    logic             n_lv    [LANES];
    logic             n_range_ok;
    logic [RW+1:0]    n_x4, n_x4p3, n_x2p1;
    logic [NW-1:0]    n_c4, n_c4p3, n_c2p1;

    // Selection signals
    t_status          n_status;
    logic [31:0]      n_best_delta, n_best_rate;
    logic [NW-1:0]    n_best_n;
    logic [2:0]       n_best_div;
    logic             n_have;

    // Hold every stage while a finished result waits
    assign n_en    = !r_out_valid || !i_stall;
    assign o_stall = !n_en;

    pfs_ref_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (i_valid),
        .i_rate  (i_requested_rate),
        .o_res   (div_res)
    );

    // Scan bounds and the largest n per divider whose rate stays at or below
    always_comb begin
        n_x4   = {div_res.rem, 2'b00};
        n_x4p3 = n_x4 + (RW + 2)'(3);
        n_x2p1 = {1'b0, div_res.rem, 1'b1};
        n_c4   = NW'(n_x4 >= REF_X1) + NW'(n_x4 >= REF_X2) + NW'(n_x4 >= REF_X3);
        n_c4p3 = NW'(n_x4p3 >= REF_X1) + NW'(n_x4p3 >= REF_X2) + NW'(n_x4p3 >= REF_X3);
        n_c2p1 = NW'(n_x2p1 >= REF_X1);

        n_lo       = NW'(div_res.quot);
        n_hi       = (n_lo << 2) + n_c4;
        n_hi_m1    = n_hi - NW'(1);
        n_lim      = (n_hi_m1 < MAX_N) ? n_hi_m1 : MAX_N;
        n_range_ok = (n_hi > n_lo) && (n_lo <= MAX_N);

        n_nmax[0] = n_lo;
        n_nmax[1] = (n_lo << 1) + n_c2p1;
        n_nmax[2] = (n_lo << 2) + n_c4p3;

        for (int l = 0; l < LANES; l++) begin
            n_nstar[l] = (n_nmax[l] < n_lim) ? n_nmax[l] : n_lim;
            n_lv[l]    = n_range_ok && (n_nstar[l] != '0);
        end
    end

    // Pick the smallest shortfall, earliest divider first on a tie
    always_comb begin
        n_have       = 1'b0;
        n_best_delta = '0;
        n_best_rate  = '0;
        n_best_n     = '0;
        n_best_div   = '0;
        for (int l = 0; l < LANES; l++) begin
            if (r6_lv[l] && (!n_have || (r6_delta[l] < n_best_delta))) begin
                n_have       = 1'b1;
                n_best_delta = r6_delta[l];
                n_best_rate  = r6_cand[l];
                n_best_n     = r6_nstar[l];
                n_best_div   = DIV_VAL[l];
            end
        end
        if (r6_zero) begin
            n_status = ST_ZERO;
        end else if (n_have) begin
            n_status = ST_FOUND;
        end else begin
            n_status = ST_NONE;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r6_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (n_en) begin
            r4_valid    <= div_res.valid;
            r5_valid    <= r4_valid;
            r6_valid    <= r5_valid;
            r_out_valid <= r6_valid;
        end
    end

    // Advance the datapath
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r4_rate <= div_res.rate;
            r5_rate <= r4_rate;
            r6_zero <= (r5_rate == '0);
            for (int l = 0; l < LANES; l++) begin
                r4_nstar[l] <= n_nstar[l];
                r4_lv[l]    <= n_lv[l];
                r5_nstar[l] <= r4_nstar[l];
                r5_lv[l]    <= r4_lv[l];
                r5_cand[l]  <= 32'(((NW + RW)'(r4_nstar[l]) * (NW + RW)'(REF_C))
                                   >> DIV_SHIFT[l]);
                r6_nstar[l] <= r5_nstar[l];
                r6_lv[l]    <= r5_lv[l];
                r6_cand[l]  <= r5_cand[l];
                r6_delta[l] <= r5_rate - r5_cand[l];
            end
            r_out_status <= n_status;
            if (n_status == ST_FOUND) begin
                r_out_rate <= n_best_rate;
                r_out_mul  <= n_best_n[7:0];
                r_out_div  <= n_best_div;
            end else begin
                r_out_rate <= '0;
                r_out_mul  <= '0;
                r_out_div  <= '0;
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_status            = r_out_status;
    assign o_chosen_rate       = r_out_rate;
    assign o_chosen_multiplier = r_out_mul;
    assign o_chosen_divider    = r_out_div;

endmodule

FILE: verif/tb_top.sv
// Self-checking bench for pll_factor_search: corner requests, then random ones.
// Predicts each search in place; needs pfs_pkg and the pll_factor_search RTL only.
`timescale 1ns / 1ps

module tb_top
    import pfs_pkg::*;
();

    localparam int RANDOM_REQUESTS = 400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES     = 16;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int MODE_EVERY      = 32;

    localparam int GAP_NONE  = 0;
    localparam int GAP_SHORT = 1;
    localparam int GAP_LONG  = 2;

    // Rates that sit on the edges of the search
    localparam int N_CORNERS = 23;
    localparam logic [31:0] CORNER_RATES [N_CORNERS] = '{
        32'd0,          32'd1,          32'd5999999,    32'd6000000,
        32'd6000001,    32'd11999999,   32'd12000000,   32'd18000000,
        32'd23999999,   32'd24000000,   32'd24000001,   32'd36000000,
        32'd47999999,   32'd1529999999, 32'd1530000000, 32'd1530000001,
        32'd1536000000, 32'd3060000000, 32'd4284000000, 32'hFFFF_FFFF,
        32'h8000_0000,  32'h5555_5555,  32'hAAAA_AAAA
    };

    typedef struct {
        t_status     status;
        logic [31:0] rate;
        logic [7:0]  mult;
        logic [2:0]  div;
    } t_pll_pick;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_requested_rate = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_chosen_rate;
    logic [7:0]  o_chosen_multiplier;
    logic [2:0]  o_chosen_divider;

    logic [31:0] pending_rates [$];
    t_pll_pick   expected_picks [$];

    // Sender state
    logic        src_live = 1'b0;
    logic [31:0] src_rate = '0;
    int          src_gap = 0;
    int          src_mode = GAP_NONE;
    int          src_count = 0;
    logic        req_taken = 1'b0;

    // Receiver state
    int          snk_wait = 0;
    int          snk_mode = GAP_NONE;
    int          snk_count = 0;
    int          hold_left = 0;
    logic        hold_kick = 1'b0;
    logic        hold_done = 1'b0;
    logic        res_taken = 1'b0;

    int          errors = 0;
    int          results_seen = 0;
    int          blocked_cycles = 0;
    int          quiet_cycles = 0;

    pll_factor_search u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_requested_rate    (i_requested_rate),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_status            (o_status),
        .o_chosen_rate       (o_chosen_rate),
        .o_chosen_multiplier (o_chosen_multiplier),
        .o_chosen_divider    (o_chosen_divider)
    );

    always #6 i_clk = ~i_clk;

    // Scan every divider the slow way and keep the first strictly closest rate at or below
    function automatic t_pll_pick search_factors(logic [31:0] want_rate);
        longint unsigned rate_q;
        longint unsigned ref_hz;
        longint unsigned n_first;
        longint unsigned n_stop;
        longint unsigned short_best;
        longint unsigned cand;
        longint unsigned n;
        longint unsigned m;
        longint unsigned best_n;
        longint unsigned best_m;
        longint unsigned best_rate;
        t_pll_pick       pick;
        rate_q     = want_rate;
        ref_hz     = REF_CLOCK_HZ;
        short_best = rate_q;
        best_n     = 0;
        best_m     = 0;
        best_rate  = 0;
        pick.status = ST_NONE;
        pick.rate   = '0;
        pick.mult   = '0;
        pick.div    = '0;
        if (rate_q == 0) begin
            pick.status = ST_ZERO;
            return pick;
        end
        n_first = rate_q / ref_hz;
        n_stop  = (rate_q * 4) / ref_hz;
        for (int d = 0; d < LANES; d++) begin
            m = DIV_VAL[d];
            for (n = n_first; n < n_stop; n++) begin
                if (n > MAX_MULTIPLIER) break;
                cand = (n * ref_hz) / m;
                if (cand > rate_q) break;
                if (rate_q - cand < short_best) begin
                    short_best = rate_q - cand;
                    best_n     = n;
                    best_m     = m;
                    best_rate  = cand;
                end
                if (cand == rate_q) break;
            end
        end
        if (best_n != 0 && best_m != 0) begin
            pick.status = ST_FOUND;
            pick.rate   = best_rate[31:0];
            pick.mult   = best_n[7:0];
            pick.div    = best_m[2:0];
        end
        return pick;
    endfunction

    function automatic int idle_cycles(int mode);
        case (mode)
            GAP_NONE:  return 0;
            GAP_SHORT: return $urandom_range(0, 3);
            GAP_LONG:  return $urandom_range(0, 14);
            default:   return 0;
        endcase
    endfunction

    // Rates on and near the 6 MHz candidate grid, plus random values, ranges and bit patterns
    function automatic logic [31:0] draw_rate();
        longint unsigned k;
        logic [31:0]     r;
        case ($urandom_range(0, 5))
            0: r = $urandom();
            1: r = $urandom_range(0, 48000000);
            2: begin
                k = $urandom_range(1, 715);
                r = 32'(k * 6000000);
            end
            3: begin
                k = $urandom_range(1, 714);
                r = 32'(k * 6000000 + $urandom_range(0, 2000) - 1000);
            end
            4: r = $urandom_range(1480000000, 1590000000);
            default: begin
                r = 32'd1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1)) r = ~r;
            end
        endcase
        return r;
    endfunction

    // Offer the next pending request and hold it until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (src_live && req_taken) src_live = 1'b0;
            if (!src_live) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_rates.size() > 0) begin
                    src_rate = pending_rates.pop_front();
                    src_live = 1'b1;
                    if (src_count % MODE_EVERY == 0) src_mode = $urandom_range(0, 2);
                    src_count++;
                    src_gap = idle_cycles(src_mode);
                end
            end
            i_valid <= src_live;
            if (src_live) i_requested_rate <= src_rate;
        end
    end

    // Stall results at random, plus one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (hold_kick && !hold_done) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_done = 1'b1;
            end
            if (res_taken) begin
                if (snk_count % MODE_EVERY == 0) snk_mode = $urandom_range(0, 2);
                snk_count++;
                snk_wait = idle_cycles(snk_mode);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (snk_wait > 0 && o_valid) begin
                snk_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Predict each accepted request and check each accepted result
    always @(posedge i_clk) begin
        t_pll_pick want;
        t_pll_pick got;
        if (i_rst_n) begin
            if (i_valid && o_stall) blocked_cycles++;
            if (i_valid && !o_stall) expected_picks.push_back(search_factors(i_requested_rate));
            if (o_valid && !i_stall) begin
                got.status = t_status'(o_status);
                got.rate   = o_chosen_rate;
                got.mult   = o_chosen_multiplier;
                got.div    = o_chosen_divider;
                results_seen++;
                if (expected_picks.size() == 0) begin
                    $display("%0t: result with none expected: status %0d rate %0d n %0d m %0d",
                             $time, got.status, got.rate, got.mult, got.div);
                    errors++;
                end else begin
                    want = expected_picks.pop_front();
                    if (got.status != want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        errors++;
                    end
                    if (got.rate != want.rate) begin
                        $display("%0t: chosen_rate expected %0d actual %0d",
                                 $time, want.rate, got.rate);
                        errors++;
                    end
                    if (got.mult != want.mult) begin
                        $display("%0t: chosen_multiplier expected %0d actual %0d",
                                 $time, want.mult, got.mult);
                        errors++;
                    end
                    if (got.div != want.div) begin
                        $display("%0t: chosen_divider expected %0d actual %0d",
                                 $time, want.div, got.div);
                        errors++;
                    end
                end
            end
        end
        req_taken <= i_rst_n && i_valid && !o_stall;
        res_taken <= i_rst_n && o_valid && !i_stall;
    end

    // Give up if neither side moves a beat for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_picks.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Reset, corner requests, then the random batch behind a long hold-off
    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (CORNER_RATES[i]) pending_rates.push_back(CORNER_RATES[i]);
        while (pending_rates.size() != 0 || src_live || expected_picks.size() != 0)
            @(posedge i_clk);
        hold_kick = 1'b1;
        for (int i = 0; i < RANDOM_REQUESTS; i++) pending_rates.push_back(draw_rate());
        while (pending_rates.size() != 0 || src_live || expected_picks.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Searched %0d requests (%0d corner, %0d random), %0d results compared.",
                 src_count, N_CORNERS, RANDOM_REQUESTS, results_seen);
        $display("Input held off by back-pressure for %0d cycles; %0d field mismatches.",
                 blocked_cycles, errors);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: pll_factor_search.f
hdl/pfs_pkg.sv
hdl/pfs_ref_div.sv
hdl/pll_factor_search.sv
verif/tb_top.sv
